// File: hw/rtl/glyb_pkg.sv
// Package for the glyph blitter: store sizing, command and state types,
// and the structs passed between the front and back halves.
// No dependencies.
`default_nettype none

package glyb_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_COLS  = 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(GLYPH_ROWS * GLYPH_COLS * 2);
  localparam int TILE_W      = 12;
  localparam int PIX_W       = TILE_W + 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [5:0] STRIDE_RESET = 6'd32;
  localparam logic [7:0] LO_MASK      = 8'h0F;
  localparam logic [7:0] HI_MASK      = 8'hF0;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PIX,
    BK_CALC,
    BK_MERGE,
    BK_RD,
    BK_RD_WAIT,
    BK_WR,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    opcode_t     op;
    logic        byte_ok;
    logic [4:0]  base_tile_row;
    logic [2:0]  row_in_tile;
    logic [7:0]  x_pixel;
    logic [3:0]  width;
    logic [3:0]  palette_index;
    logic [63:0] upper_rows;
    logic [63:0] lower_rows;
    logic [11:0] byte_address;
    logic [7:0]  write_data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fe_req_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } be_ack_t;

endpackage

`default_nettype wire

// File: hw/rtl/glyb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module glyb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/glyb_front.sv
// Front half: accepts command beats, classifies them and queues them
// for the back half. Depends on glyb_pkg.
`default_nettype none

module glyb_front
  import glyb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [4:0]  base_tile_row,
  input  wire logic [2:0]  row_in_tile,
  input  wire logic [7:0]  x_pixel,
  input  wire logic [3:0]  glyph_width,
  input  wire logic [3:0]  palette_index,
  input  wire logic [63:0] upper_rows,
  input  wire logic [63:0] lower_rows,
  input  wire logic [11:0] byte_address,
  input  wire logic [7:0]  write_data,
  output fe_req_t          req,
  input  wire be_ack_t     ack
);

  cmd_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              full;
  logic              push;
  cmd_t              cls;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign cmd_stall = full || ack.clearing;
  assign push      = cmd_valid && !cmd_stall;

  always_comb begin
    cls.op            = opcode_t'(opcode);
    cls.byte_ok       = (32'(byte_address) < STORE_BYTES);
    cls.base_tile_row = base_tile_row;
    cls.row_in_tile   = row_in_tile;
    cls.x_pixel       = x_pixel;
    cls.width         = (32'(glyph_width) > GLYPH_COLS) ? 4'(GLYPH_COLS) : glyph_width;
    cls.palette_index = palette_index;
    cls.upper_rows    = upper_rows;
    cls.lower_rows    = lower_rows;
    cls.byte_address  = byte_address;
    cls.write_data    = write_data;
  end

  assign req.valid = (count != '0);
  assign req.cmd   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (ack.pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !ack.pop) begin
        count <= count + 1'b1;
      end else if (!push && ack.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    ack.clearing |-> (count == '0))
    else $error("queue holds beats during clearing pass");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    ack.pop |-> (count != '0))
    else $error("pop from empty queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule

`default_nettype wire

// File: hw/rtl/glyb_back.sv
// Back half: clears the store after reset, then runs queued commands:
// per-pixel nibble read-modify-write for glyphs, byte read and write.
// Depends on glyb_pkg; drives the ports of one glyb_ram.
`default_nettype none

module glyb_back
  import glyb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [5:0]        tiles_per_row,
  input  wire fe_req_t           req,
  output be_ack_t                ack,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [7:0]             ram_wdata,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  wire logic [7:0]        ram_rdata,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [7:0]             read_data,
  output logic                   out_of_range
);

  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] clear_cnt;
  cmd_t              cur;
  logic [POS_W-1:0]  pos;
  logic              pos_last;
  logic              oor_acc;
  logic [7:0]        rd_acc;

  logic [TILE_W-1:0] mul_q;
  logic [5:0]        xh_q;
  logic [4:0]        within_q;
  logic              nib_q;
  logic [PIX_W-1:0]  pix_q;

  logic              half;
  logic [2:0]        col;
  logic [2:0]        row;
  logic              pix_bit;
  logic              pix_active;
  logic [3:0]        y;
  logic [8:0]        x;
  logic [5:0]        tile_row;
  logic [TILE_W-1:0] tile;
  logic [PIX_W-1:0]  pix_addr;
  logic              pix_ok;
  logic [7:0]        merged;

  logic pop;
  logic cur_load;
  logic pos_inc;
  logic calc_load;
  logic pix_load;
  logic oor_set;
  logic rd_load;
  logic res_load;

  assign half     = pos[0];
  assign col      = pos[3:1];
  assign row      = pos[POS_W-1:4];
  assign pos_last = (pos == '1);
  assign pix_bit  = half ? cur.lower_rows[{row, col}] : cur.upper_rows[{row, col}];
  assign pix_active = pix_bit && ({1'b0, col} < cur.width);

  assign y        = {1'b0, cur.row_in_tile} + {1'b0, row};
  assign x        = {1'b0, cur.x_pixel} + {6'd0, col};
  assign tile_row = {1'b0, cur.base_tile_row} + {5'd0, y[3]} + {5'd0, half};

  assign tile     = mul_q + {6'd0, xh_q};
  assign pix_addr = {tile, within_q};
  assign pix_ok   = (32'(pix_addr) < STORE_BYTES);
  assign merged   = nib_q ? ((ram_rdata & LO_MASK) | {cur.palette_index, 4'd0})
                          : ((ram_rdata & HI_MASK) | {4'd0, cur.palette_index});

  assign ack.pop      = pop;
  assign ack.clearing = (state == BK_CLEAR);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    cur_load   = 1'b0;
    pos_inc    = 1'b0;
    calc_load  = 1'b0;
    pix_load   = 1'b0;
    oor_set    = 1'b0;
    rd_load    = 1'b0;
    res_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_cnt;
        if (clear_cnt == ADDR_W'(STORE_BYTES - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (req.valid) begin
          pop      = 1'b1;
          cur_load = 1'b1;
          case (req.cmd.op)
            OP_DRAW:  state_next = BK_PIX;
            OP_READ:  state_next = BK_RD;
            OP_WRITE: state_next = BK_WR;
            default:  state_next = BK_DONE;
          endcase
        end
      end
      BK_PIX: begin
        if (pix_active) begin
          calc_load  = 1'b1;
          state_next = BK_CALC;
        end else if (pos_last) begin
          state_next = BK_DONE;
        end else begin
          pos_inc = 1'b1;
        end
      end
      BK_CALC: begin
        if (pix_ok) begin
          ram_raddr  = ADDR_W'(pix_addr);
          pix_load   = 1'b1;
          state_next = BK_MERGE;
        end else begin
          oor_set = 1'b1;
          if (pos_last) begin
            state_next = BK_DONE;
          end else begin
            pos_inc    = 1'b1;
            state_next = BK_PIX;
          end
        end
      end
      BK_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(pix_q);
        ram_wdata = merged;
        if (pos_last) begin
          state_next = BK_DONE;
        end else begin
          pos_inc    = 1'b1;
          state_next = BK_PIX;
        end
      end
      BK_RD: begin
        if (cur.byte_ok) begin
          ram_raddr  = ADDR_W'(cur.byte_address);
          state_next = BK_RD_WAIT;
        end else begin
          oor_set    = 1'b1;
          state_next = BK_DONE;
        end
      end
      BK_RD_WAIT: begin
        rd_load    = 1'b1;
        state_next = BK_DONE;
      end
      BK_WR: begin
        if (cur.byte_ok) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(cur.byte_address);
          ram_wdata = cur.write_data;
        end else begin
          oor_set = 1'b1;
        end
        state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clear_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur     <= req.cmd;
      pos     <= '0;
      oor_acc <= 1'b0;
      rd_acc  <= '0;
    end else begin
      if (pos_inc) begin
        pos <= pos + 1'b1;
      end
      if (oor_set) begin
        oor_acc <= 1'b1;
      end
      if (rd_load) begin
        rd_acc <= ram_rdata;
      end
    end
    if (calc_load) begin
      mul_q    <= {6'd0, tile_row} * {6'd0, tiles_per_row};
      xh_q     <= x[8:3];
      within_q <= {y[2:0], x[2:1]};
      nib_q    <= x[0];
    end
    if (pix_load) begin
      pix_q <= pix_addr;
    end
    if (res_load) begin
      read_data    <= rd_acc;
      out_of_range <= oor_acc;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == BK_DONE))
    else $error("result raised outside completion");

  a_calc_exit: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CALC) |=> (state == BK_MERGE || state == BK_PIX || state == BK_DONE))
    else $error("bad exit from address stage");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == BK_CLEAR) |-> !res_valid)
    else $error("result pending during clearing pass");

endmodule

`default_nettype wire

// File: hw/rtl/glyph_blit_4bpp_tiles.sv
// Top level of the 4bpp tile glyph blitter: stride register, front queue,
// back sequencer and tile store. Depends on glyb_pkg, glyb_front,
// glyb_back and glyb_ram.
//
//   channel   | handshake                 | payload
//   command   | cmd_valid / cmd_stall     | opcode .. write_data
//   result    | res_valid / res_stall     | read_data, out_of_range
//   stride    | stride_we                 | stride_wdata
//
// Glyph draw: queue pop, a step per glyph position (128), then per set pixel in the width
// an address step that issues the read and a merge-write, or past the store an address
// step that flags out_of_range; result load last. Byte read: pop, read, capture, result;
// write: pop, write, result. After reset the store is swept to zero, one byte a cycle, with
// cmd_stall high. A two-beat queue takes commands while the back half is busy or
// res_stall holds a finished result.
`default_nettype none

module glyph_blit_4bpp_tiles
  import glyb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        stride_we,
  input  wire logic [5:0]  stride_wdata,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [4:0]  base_tile_row,
  input  wire logic [2:0]  row_in_tile,
  input  wire logic [7:0]  x_pixel,
  input  wire logic [3:0]  glyph_width,
  input  wire logic [3:0]  palette_index,
  input  wire logic [63:0] upper_rows,
  input  wire logic [63:0] lower_rows,
  input  wire logic [11:0] byte_address,
  input  wire logic [7:0]  write_data,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       read_data,
  output logic             out_of_range
);

  logic [5:0]        tiles_per_row;
  fe_req_t           req;
  be_ack_t           ack;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tiles_per_row <= STRIDE_RESET;
    end else if (stride_we) begin
      tiles_per_row <= stride_wdata;
    end
  end

  glyb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .opcode        (opcode),
    .base_tile_row (base_tile_row),
    .row_in_tile   (row_in_tile),
    .x_pixel       (x_pixel),
    .glyph_width   (glyph_width),
    .palette_index (palette_index),
    .upper_rows    (upper_rows),
    .lower_rows    (lower_rows),
    .byte_address  (byte_address),
    .write_data    (write_data),
    .req           (req),
    .ack           (ack)
  );

  glyb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tiles_per_row (tiles_per_row),
    .req           (req),
    .ack           (ack),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .read_data     (read_data),
    .out_of_range  (out_of_range)
  );

  glyb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
